[hw/rtl/hsl_to_rgb_converter_macros.svh]
// Assertion macros for the HSL to RGB converter.
// Included by the top level; define ASSERT_OFF to compile the checks away.
`ifndef HSL_TO_RGB_CONVERTER_MACROS_SVH
`define HSL_TO_RGB_CONVERTER_MACROS_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, sampled on the rising clock edge, off during reset
`define HSL2RGB_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hsl_to_rgb_converter: assertion failed");
// Next-cycle implication, sampled on the rising clock edge, off during reset
`define HSL2RGB_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hsl_to_rgb_converter: assertion failed");
`else
`define HSL2RGB_ASSERT_IMP(label, clk, rst, ante, cons)
`define HSL2RGB_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

[hw/rtl/hsl2rgb_pkg.sv]
// Shared types and constants for the HSL to RGB converter.
// No dependencies; used by hsl2rgb_prep, hsl2rgb_chan and the top level.
`default_nettype none

package hsl2rgb_pkg;

  // Field widths
  localparam int HUE_W   = 13;
  localparam int SL_W    = 9;
  localparam int CH_W    = 8;
  localparam int C16_W   = 17;  // chroma, scale 2^16
  localparam int M17_W   = 18;  // m, scale 2^17
  localparam int K_W     = 10;  // per-channel hue weight, 0..960
  localparam int N_W     = 13;  // scaled channel before the divide by 15

  // Pipeline depth, output register included
  localparam int NUM_STAGES = 7;

  // Range limits
  localparam logic [HUE_W-1:0] HUE_LIMIT = 13'd5760;
  localparam logic [SL_W-1:0]  ONE_Q8    = 9'd256;

  // Hue sector boundaries in 1/16 degree
  localparam logic [HUE_W-1:0] BOUND_1 = 13'd960;
  localparam logic [HUE_W-1:0] BOUND_2 = 13'd1920;
  localparam logic [HUE_W-1:0] BOUND_3 = 13'd2880;
  localparam logic [HUE_W-1:0] BOUND_4 = 13'd3840;
  localparam logic [HUE_W-1:0] BOUND_5 = 13'd4800;
  localparam logic [10:0]      SPAN_11 = 11'd960;
  localparam logic [K_W-1:0]   K_FULL  = 10'd960;

  // Output scaling: half of 2^17 * 960, divide by 15 reciprocal, clamp point
  localparam logic [35:0]    HALF_D    = 36'd62914560;
  localparam logic [12:0]    RECIP_15  = 13'd4370;
  localparam logic [N_W-1:0] N_SAT     = 13'd3840;

  typedef enum logic [2:0] {
    SECTOR_RY = 3'd0,
    SECTOR_YG = 3'd1,
    SECTOR_GC = 3'd2,
    SECTOR_CB = 3'd3,
    SECTOR_BM = 3'd4,
    SECTOR_MR = 3'd5
  } hsl2rgb_sector_t;

  // Register loads for a group of three pipeline stages
  typedef struct packed {
    logic load_a;
    logic load_b;
    logic load_c;
  } hsl2rgb_load_t;

  // Front-end result handed to the channel units
  typedef struct packed {
    logic [C16_W-1:0] c16;
    logic [M17_W-1:0] m17;
    logic [K_W-1:0]   k_red;
    logic [K_W-1:0]   k_green;
    logic [K_W-1:0]   k_blue;
    logic             out_of_range;
  } hsl2rgb_prep_t;

endpackage

`default_nettype wire

[hw/rtl/hsl2rgb_prep.sv]
// Front end of the converter: range check, hue sector, chroma and m.
// Three register stages; depends on hsl2rgb_pkg.
`default_nettype none

module hsl2rgb_prep (
  input  wire logic                           clk,
  input  wire hsl2rgb_pkg::hsl2rgb_load_t     load,
  input  wire logic [hsl2rgb_pkg::HUE_W-1:0]  hue,
  input  wire logic [hsl2rgb_pkg::SL_W-1:0]   saturation,
  input  wire logic [hsl2rgb_pkg::SL_W-1:0]   lightness,
  output hsl2rgb_pkg::hsl2rgb_prep_t          prep
);

  // Stage A combinational terms
  logic                              oor_next;
  hsl2rgb_pkg::hsl2rgb_sector_t      sector_next;
  logic [hsl2rgb_pkg::HUE_W-1:0]     base;
  logic [hsl2rgb_pkg::HUE_W-1:0]     hm_full;
  logic [10:0]                       hm;
  logic [10:0]                       hd_full;
  logic [hsl2rgb_pkg::K_W-1:0]       kx_next;
  logic [9:0]                        two_l;
  logic [9:0]                        light_dev;
  logic [hsl2rgb_pkg::SL_W-1:0]      ld_next;

  // Stage A registers
  logic                              a_oor;
  hsl2rgb_pkg::hsl2rgb_sector_t      a_sector;
  logic [hsl2rgb_pkg::K_W-1:0]       a_kx;
  logic [hsl2rgb_pkg::SL_W-1:0]      a_sat;
  logic [hsl2rgb_pkg::SL_W-1:0]      a_ld;
  logic [hsl2rgb_pkg::SL_W-1:0]      a_light;

  // Stage B registers
  logic [17:0]                       c16_full;
  logic                              b_oor;
  hsl2rgb_pkg::hsl2rgb_sector_t      b_sector;
  logic [hsl2rgb_pkg::K_W-1:0]       b_kx;
  logic [hsl2rgb_pkg::C16_W-1:0]     b_c16;
  logic [hsl2rgb_pkg::SL_W-1:0]      b_light;

  // Stage C terms
  hsl2rgb_pkg::hsl2rgb_prep_t        prep_next;

  // Range check, sector, distance from the middle of the sector pair, |2L - 1|
  always_comb begin
    oor_next = (hue >= hsl2rgb_pkg::HUE_LIMIT) || (saturation > hsl2rgb_pkg::ONE_Q8) ||
               (lightness > hsl2rgb_pkg::ONE_Q8);
    if (hue < hsl2rgb_pkg::BOUND_1) begin
      sector_next = hsl2rgb_pkg::SECTOR_RY;
    end else if (hue < hsl2rgb_pkg::BOUND_2) begin
      sector_next = hsl2rgb_pkg::SECTOR_YG;
    end else if (hue < hsl2rgb_pkg::BOUND_3) begin
      sector_next = hsl2rgb_pkg::SECTOR_GC;
    end else if (hue < hsl2rgb_pkg::BOUND_4) begin
      sector_next = hsl2rgb_pkg::SECTOR_CB;
    end else if (hue < hsl2rgb_pkg::BOUND_5) begin
      sector_next = hsl2rgb_pkg::SECTOR_BM;
    end else begin
      sector_next = hsl2rgb_pkg::SECTOR_MR;
    end
    // hue mod 1920 from the pair of sectors it falls in
    if (hue < hsl2rgb_pkg::BOUND_2) begin
      base = '0;
    end else if (hue < hsl2rgb_pkg::BOUND_4) begin
      base = hsl2rgb_pkg::BOUND_2;
    end else begin
      base = hsl2rgb_pkg::BOUND_4;
    end
    hm_full = hue - base;
    hm      = hm_full[10:0];
    if (hm >= hsl2rgb_pkg::SPAN_11) begin
      hd_full = hm - hsl2rgb_pkg::SPAN_11;
    end else begin
      hd_full = hsl2rgb_pkg::SPAN_11 - hm;
    end
    kx_next = hsl2rgb_pkg::K_FULL - hd_full[9:0];
    two_l   = {lightness, 1'b0};
    if (two_l >= {1'b0, hsl2rgb_pkg::ONE_Q8}) begin
      light_dev = two_l - {1'b0, hsl2rgb_pkg::ONE_Q8};
    end else begin
      light_dev = {1'b0, hsl2rgb_pkg::ONE_Q8} - two_l;
    end
    ld_next = hsl2rgb_pkg::ONE_Q8 - light_dev[8:0];
  end

  always_ff @(posedge clk) begin
    if (load.load_a) begin
      a_oor    <= oor_next;
      a_sector <= sector_next;
      a_kx     <= kx_next;
      a_sat    <= saturation;
      a_ld     <= ld_next;
      a_light  <= lightness;
    end
  end

  // Chroma C = S * (1 - |2L - 1|), scale 2^16
  assign c16_full = a_sat * a_ld;

  always_ff @(posedge clk) begin
    if (load.load_b) begin
      b_oor    <= a_oor;
      b_sector <= a_sector;
      b_kx     <= a_kx;
      b_c16    <= c16_full[hsl2rgb_pkg::C16_W-1:0];
      b_light  <= a_light;
    end
  end

  // m = L - C/2 at scale 2^17, and the per-sector channel weights
  always_comb begin
    prep_next.c16          = b_c16;
    prep_next.m17          = {b_light, 9'b0} - {1'b0, b_c16};
    prep_next.out_of_range = b_oor;
    prep_next.k_red        = '0;
    prep_next.k_green      = '0;
    prep_next.k_blue       = '0;
    case (b_sector)
      hsl2rgb_pkg::SECTOR_RY: begin
        prep_next.k_red   = hsl2rgb_pkg::K_FULL;
        prep_next.k_green = b_kx;
      end
      hsl2rgb_pkg::SECTOR_YG: begin
        prep_next.k_red   = b_kx;
        prep_next.k_green = hsl2rgb_pkg::K_FULL;
      end
      hsl2rgb_pkg::SECTOR_GC: begin
        prep_next.k_green = hsl2rgb_pkg::K_FULL;
        prep_next.k_blue  = b_kx;
      end
      hsl2rgb_pkg::SECTOR_CB: begin
        prep_next.k_green = b_kx;
        prep_next.k_blue  = hsl2rgb_pkg::K_FULL;
      end
      hsl2rgb_pkg::SECTOR_BM: begin
        prep_next.k_red   = b_kx;
        prep_next.k_blue  = hsl2rgb_pkg::K_FULL;
      end
      default: begin
        prep_next.k_red   = hsl2rgb_pkg::K_FULL;
        prep_next.k_blue  = b_kx;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (load.load_c) begin
      prep <= prep_next;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/hsl2rgb_chan.sv]
// One colour channel: value = m + C*k/960, scaled by 255 with rounding.
// Three register stages and a divide-by-15 reciprocal; depends on hsl2rgb_pkg.
`default_nettype none

module hsl2rgb_chan (
  input  wire logic                           clk,
  input  wire hsl2rgb_pkg::hsl2rgb_load_t     load,
  input  wire logic [hsl2rgb_pkg::C16_W-1:0]  c16,
  input  wire logic [hsl2rgb_pkg::M17_W-1:0]  m17,
  input  wire logic [hsl2rgb_pkg::K_W-1:0]    k,
  output logic      [hsl2rgb_pkg::CH_W-1:0]   chan
);

  logic [26:0]                   prod_next;
  logic [27:0]                   m960_next;
  logic [26:0]                   a_prod;
  logic [27:0]                   a_m960;
  logic [27:0]                   b_v;
  logic [35:0]                   w;
  logic [hsl2rgb_pkg::N_W-1:0]   c_n;
  logic [24:0]                   q_full;

  // Stage A: C*k and m*960 (shift-subtract)
  assign prod_next = c16 * k;
  assign m960_next = {m17, 10'b0} - {4'b0, m17, 6'b0};

  always_ff @(posedge clk) begin
    if (load.load_a) begin
      a_prod <= prod_next;
      a_m960 <= m960_next;
    end
  end

  // Stage B: channel value at scale 2^17 * 960
  always_ff @(posedge clk) begin
    if (load.load_b) begin
      b_v <= a_m960 + {a_prod, 1'b0};
    end
  end

  // Stage C: times 255 plus half a unit, then drop 2^17 * 64
  assign w = {b_v, 8'b0} - {8'b0, b_v} + hsl2rgb_pkg::HALF_D;

  always_ff @(posedge clk) begin
    if (load.load_c) begin
      c_n <= w[35:23];
    end
  end

  // Divide by 15 through the reciprocal, clamp to full scale
  assign q_full = c_n[11:0] * hsl2rgb_pkg::RECIP_15;
  assign chan   = (c_n >= hsl2rgb_pkg::N_SAT) ? {hsl2rgb_pkg::CH_W{1'b1}} : q_full[23:16];

endmodule

`default_nettype wire

[hw/rtl/hsl_to_rgb_converter.sv]
// HSL to RGB converter, top level: handshake control and output register.
// Uses hsl2rgb_pkg, hsl2rgb_prep, hsl2rgb_chan and the assertion macro header.
//
// Usage:
//   Request channel hsl_valid/hsl_ready carries hue (1/16 degree), saturation
//   and lightness (Q1.8, 256 = 1.0). Result channel rgb_valid/rgb_ready carries
//   red, green, blue (8 bits each) and out_of_range. An out-of-range request
//   (hue 5760 or more, saturation or lightness above 256) yields black with
//   out_of_range set.
//   rgb_valid rises once a request has passed the seven-stage pipeline (three
//   front-end stages, three channel stages, one output register), each stage
//   holding one request; throughput is one request per cycle while the
//   receiver does not stall.
//   Reset clears all stage valid bits; the pipeline is empty afterwards and
//   hsl_ready is high from the first cycle.
//   When the receiver stalls, the result holds in the output register and
//   earlier stages keep advancing into empty slots; hsl_ready falls only once
//   all seven stages hold requests.
`default_nettype none
`include "hsl_to_rgb_converter_macros.svh"

module hsl_to_rgb_converter (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           hsl_valid,
  output logic                                hsl_ready,
  input  wire logic [hsl2rgb_pkg::HUE_W-1:0]  hue,
  input  wire logic [hsl2rgb_pkg::SL_W-1:0]   saturation,
  input  wire logic [hsl2rgb_pkg::SL_W-1:0]   lightness,
  output logic                                rgb_valid,
  input  wire logic                           rgb_ready,
  output logic      [hsl2rgb_pkg::CH_W-1:0]   red,
  output logic      [hsl2rgb_pkg::CH_W-1:0]   green,
  output logic      [hsl2rgb_pkg::CH_W-1:0]   blue,
  output logic                                out_of_range
);

  logic [hsl2rgb_pkg::NUM_STAGES-1:0] vld;
  logic [hsl2rgb_pkg::NUM_STAGES-1:0] en;
  hsl2rgb_pkg::hsl2rgb_load_t         prep_load;
  hsl2rgb_pkg::hsl2rgb_load_t         chan_load;
  hsl2rgb_pkg::hsl2rgb_prep_t         prep;
  logic [hsl2rgb_pkg::CH_W-1:0]       red_chan;
  logic [hsl2rgb_pkg::CH_W-1:0]       green_chan;
  logic [hsl2rgb_pkg::CH_W-1:0]       blue_chan;
  logic                               oor_d1;
  logic                               oor_d2;
  logic                               oor_d3;

  // A stage loads when it is empty or its content moves on
  always_comb begin
    en[hsl2rgb_pkg::NUM_STAGES-1] = !vld[hsl2rgb_pkg::NUM_STAGES-1] || rgb_ready;
    for (int i = hsl2rgb_pkg::NUM_STAGES - 2; i >= 0; i--) begin
      en[i] = !vld[i] || en[i+1];
    end
  end

  assign hsl_ready = en[0];
  assign rgb_valid = vld[hsl2rgb_pkg::NUM_STAGES-1];

  // Advance valid bits with their stages
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= hsl_valid;
      end
      for (int i = 1; i < hsl2rgb_pkg::NUM_STAGES; i++) begin
        if (en[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  assign prep_load = '{load_a: en[0], load_b: en[1], load_c: en[2]};
  assign chan_load = '{load_a: en[3], load_b: en[4], load_c: en[5]};

  hsl2rgb_prep u_prep (
    .clk        (clk),
    .load       (prep_load),
    .hue        (hue),
    .saturation (saturation),
    .lightness  (lightness),
    .prep       (prep)
  );

  hsl2rgb_chan u_red (
    .clk  (clk),
    .load (chan_load),
    .c16  (prep.c16),
    .m17  (prep.m17),
    .k    (prep.k_red),
    .chan (red_chan)
  );

  hsl2rgb_chan u_green (
    .clk  (clk),
    .load (chan_load),
    .c16  (prep.c16),
    .m17  (prep.m17),
    .k    (prep.k_green),
    .chan (green_chan)
  );

  hsl2rgb_chan u_blue (
    .clk  (clk),
    .load (chan_load),
    .c16  (prep.c16),
    .m17  (prep.m17),
    .k    (prep.k_blue),
    .chan (blue_chan)
  );

  // Carry the range flag alongside the channel stages
  always_ff @(posedge clk) begin
    if (en[3]) begin
      oor_d1 <= prep.out_of_range;
    end
    if (en[4]) begin
      oor_d2 <= oor_d1;
    end
    if (en[5]) begin
      oor_d3 <= oor_d2;
    end
  end

  // Output register: black for an out-of-range request
  always_ff @(posedge clk) begin
    if (en[hsl2rgb_pkg::NUM_STAGES-1]) begin
      red          <= oor_d3 ? '0 : red_chan;
      green        <= oor_d3 ? '0 : green_chan;
      blue         <= oor_d3 ? '0 : blue_chan;
      out_of_range <= oor_d3;
    end
  end

  // Checks
  `HSL2RGB_ASSERT_IMP(a_oor_black, clk, rst, rgb_valid && out_of_range, (red == '0) && (green == '0) && (blue == '0))
  `HSL2RGB_ASSERT_IMP(a_stall_full, clk, rst, !hsl_ready, rgb_valid && !rgb_ready)
  `HSL2RGB_ASSERT_NXT(a_fill_order, clk, rst, !rgb_valid && !vld[hsl2rgb_pkg::NUM_STAGES-2], !rgb_valid)

endmodule

`default_nettype wire
